@@ src/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the max tracking stack unit.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic        [STATUS_W-1:0] status_t;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // shift command for one row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ src/mts_cell.sv @@
// ----------------------------------------------------------------------------
// mts_cell
// One stack cell: loads from the neighbor above on push, below on pop.
// ----------------------------------------------------------------------------
module mts_cell
(
    input  logic               clk,
    input  mts_pkg::cell_ctrl_t ctrl,
    input  mts_pkg::word_t     up_data,
    input  mts_pkg::word_t     down_data,
    output mts_pkg::word_t     data
);
    import mts_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        priority if (ctrl.push)
        begin
            data_next = up_data;
        end
        else if (ctrl.pop)
        begin
            data_next = down_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ src/max_tracking_stack_unit.sv @@
// ----------------------------------------------------------------------------
// max_tracking_stack_unit
// Bounded stack of signed words with a running maximum kept on a second stack.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser
//  s_      | in        | value[31:0]                    | kind
//  m_      | out       | popped_value[31:0], max[63:32] | status[1:0], max_valid[2]
//
//  Unless stalled, one transaction per cycle; results are registered on accept.
//  Both stacks are shifting cell rows with the top in cell 0, so a push or
//  pop moves every cell of the row at once.
//  rst_n clears the counts and the output valid; cell contents are not reset.
//  A stalled result is held in the output register; s_tready drops meanwhile.
// ----------------------------------------------------------------------------
module max_tracking_stack_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // popped_value, max_value
    output logic [2:0]  m_tuser    // status, max_valid
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t      ent_data [DEPTH];
    word_t      max_data [DEPTH];
    word_t      max_second;
    word_t      value;
    cell_ctrl_t ent_ctrl;
    cell_ctrl_t max_ctrl;

    logic [CNT_W-1:0] entry_cnt_reg;
    logic [CNT_W-1:0] entry_cnt_next;
    logic [CNT_W-1:0] max_cnt_reg;
    logic [CNT_W-1:0] max_cnt_next;

    logic    m_tvalid_reg;
    status_t status_reg;
    status_t status_next;
    word_t   popped_reg;
    word_t   popped_next;
    word_t   max_value_reg;
    word_t   max_value_next;
    logic    max_valid_reg;
    logic    max_valid_next;

    logic accept;
    logic is_pop;
    logic full;
    logic empty;
    logic max_empty;

    assign value    = word_t'(s_tdata);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == KIND_POP);

    assign full      = (entry_cnt_reg == CNT_W'(DEPTH));
    assign empty     = (entry_cnt_reg == '0);
    assign max_empty = (max_cnt_reg == '0);

    assign ent_ctrl.push = accept && !is_pop && !full;
    assign ent_ctrl.pop  = accept && is_pop && !empty;
    assign max_ctrl.push = ent_ctrl.push && (max_empty || (value >= max_data[0]));
    assign max_ctrl.pop  = ent_ctrl.pop && !max_empty && (ent_data[0] == max_data[0]);

    generate
        if (DEPTH > 1)
        begin : g_second
            assign max_second = max_data[1];
        end
        else
        begin : g_no_second
            assign max_second = '0;
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            word_t ent_up;
            word_t ent_down;
            word_t max_up;
            word_t max_down;

            if (i == 0)
            begin : g_top
                assign ent_up = value;
                assign max_up = value;
            end
            else
            begin : g_mid
                assign ent_up = ent_data[i-1];
                assign max_up = max_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_bottom
                assign ent_down = '0;
                assign max_down = '0;
            end
            else
            begin : g_above
                assign ent_down = ent_data[i+1];
                assign max_down = max_data[i+1];
            end

            mts_cell u_ent_cell
            (
                .clk       (clk),
                .ctrl      (ent_ctrl),
                .up_data   (ent_up),
                .down_data (ent_down),
                .data      (ent_data[i])
            );

            mts_cell u_max_cell
            (
                .clk       (clk),
                .ctrl      (max_ctrl),
                .up_data   (max_up),
                .down_data (max_down),
                .data      (max_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        entry_cnt_next = entry_cnt_reg;
        max_cnt_next   = max_cnt_reg;
        if (ent_ctrl.push)
        begin
            entry_cnt_next = entry_cnt_reg + CNT_W'(1);
        end
        if (ent_ctrl.pop)
        begin
            entry_cnt_next = entry_cnt_reg - CNT_W'(1);
        end
        if (max_ctrl.push)
        begin
            max_cnt_next = max_cnt_reg + CNT_W'(1);
        end
        if (max_ctrl.pop)
        begin
            max_cnt_next = max_cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (is_pop)
        begin
            status_next = empty ? STATUS_EMPTY : STATUS_DONE;
        end
        else
        begin
            status_next = full ? STATUS_FULL : STATUS_DONE;
        end

        popped_next    = ent_ctrl.pop ? ent_data[0] : '0;
        max_valid_next = (entry_cnt_next != '0) && (max_cnt_next != '0);

        priority if (!max_valid_next)
        begin
            max_value_next = '0;
        end
        else if (max_ctrl.push)
        begin
            max_value_next = value;
        end
        else if (max_ctrl.pop)
        begin
            max_value_next = max_second;
        end
        else
        begin
            max_value_next = max_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_cnt_reg <= '0;
            max_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            entry_cnt_reg <= entry_cnt_next;
            max_cnt_reg   <= max_cnt_next;
            if (s_tready)
            begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            popped_reg    <= popped_next;
            max_value_reg <= max_value_next;
            max_valid_reg <= max_valid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {max_value_reg, popped_reg};
    assign m_tuser  = {max_valid_reg, status_reg};

    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_max_cnt : assert property (@(posedge clk) disable iff (!rst_n)
        max_cnt_reg <= entry_cnt_reg)
        else $error("max stack deeper than entry stack");

    a_push_max : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pop && !full) |=> (m_tvalid && m_tuser[2]))
        else $error("push left no valid maximum");

    a_full_max : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == STATUS_FULL)) |-> m_tuser[2])
        else $error("full stack reported without maximum");

endmodule
